[rtl/csd_pkg.sv]
// Shared types and codes for the byte stack with delete and search.
package csd_pkg;

    // Request operation codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    localparam logic [1:0] OP_SEARCH = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_BEYOND    = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // Request payload
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] value;
        logic [4:0] position;
    } req_t;

    // Result payload
    typedef struct packed {
        logic       found;
        logic [4:0] count;
        logic [1:0] status;
    } rsp_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_MATCH,
        S_REPORT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;
        logic update;
        logic match;
        logic report;
    } cmd_t;

endpackage

[rtl/csd_ctrl.sv]
// Controller state machine that sequences one request through the datapath.
module csd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output csd_pkg::cmd_t  cmd
);

    csd_pkg::state_t state_reg;
    csd_pkg::state_t state_next;

    // Hold current state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Advance through update, match and report
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            csd_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = csd_pkg::S_UPDATE;
                end
            end
            csd_pkg::S_UPDATE: state_next = csd_pkg::S_MATCH;
            csd_pkg::S_MATCH:  state_next = csd_pkg::S_REPORT;
            csd_pkg::S_REPORT: state_next = csd_pkg::S_IDLE;
            default:           state_next = csd_pkg::S_IDLE;
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            csd_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            csd_pkg::S_UPDATE: cmd.update = 1'b1;
            csd_pkg::S_MATCH:  cmd.match  = 1'b1;
            csd_pkg::S_REPORT: cmd.report = 1'b1;
            default:           busy       = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    // A transfer in leads to a report after the update and match steps
    a_load_to_report: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> ##3 cmd.report)
        else $error("report did not follow load");

    // Commands never overlap
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.update, cmd.match, cmd.report}))
        else $error("overlapping datapath commands");

    // Report frees the block on the next cycle
    a_report_frees: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> !busy)
        else $error("busy held after report");
`endif

endmodule

[rtl/csd_dp.sv]
// Datapath: row of byte cells with shift-delete, fill level and match vector.
module csd_dp #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  csd_pkg::cmd_t  cmd,
    input  csd_pkg::req_t  req,
    output csd_pkg::rsp_t  rsp
);

    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (LVL_W > 5) ? LVL_W : 5;

    csd_pkg::req_t    req_reg;
    logic [7:0]       entry_reg  [DEPTH];
    logic [7:0]       entry_next [DEPTH];
    logic [LVL_W-1:0] fill_reg;
    logic [LVL_W-1:0] fill_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [DEPTH-1:0] match_reg;
    logic [DEPTH-1:0] match_next;
    logic [CMP_W-1:0] fill_cmp;
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] del_idx;
    logic             do_push;
    logic             do_delete;

    // Hold the request for the duration of its processing
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
    end

    // Decide the step and its status
    always_comb
    begin
        fill_cmp    = CMP_W'(fill_reg);
        pos_cmp     = CMP_W'(req_reg.position);
        del_idx     = fill_cmp - pos_cmp;
        fill_next   = fill_reg;
        status_next = csd_pkg::ST_OK;
        do_push     = 1'b0;
        do_delete   = 1'b0;
        case (req_reg.op)
            csd_pkg::OP_PUSH:
            begin
                if (fill_cmp >= CMP_W'(DEPTH))
                begin
                    status_next = csd_pkg::ST_FULL;
                end
                else
                begin
                    do_push   = 1'b1;
                    fill_next = fill_reg + LVL_W'(1);
                end
            end
            csd_pkg::OP_POP:
            begin
                if (fill_reg == '0)
                begin
                    status_next = csd_pkg::ST_POP_EMPTY;
                end
                else
                begin
                    fill_next = fill_reg - LVL_W'(1);
                end
            end
            csd_pkg::OP_DELETE:
            begin
                if (pos_cmp == '0 || pos_cmp > fill_cmp)
                begin
                    status_next = csd_pkg::ST_BEYOND;
                end
                else
                begin
                    do_delete = 1'b1;
                    fill_next = fill_reg - LVL_W'(1);
                end
            end
            csd_pkg::OP_SEARCH: status_next = csd_pkg::ST_OK;
            default:            status_next = csd_pkg::ST_OK;
        endcase
    end

    // Write the top cell on push, close up cells above the deleted one
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (do_push && fill_reg == LVL_W'(i))
            begin
                entry_next[i] = req_reg.value;
            end
            if (i + 1 < DEPTH)
            begin
                if (do_delete && CMP_W'(i) >= del_idx && CMP_W'(i + 1) < fill_cmp)
                begin
                    entry_next[i] = entry_reg[(i + 1) % DEPTH];
                end
            end
        end
    end

    // Compare every held cell with the searched byte
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            match_next[i] = (LVL_W'(i) < fill_reg) && (entry_reg[i] == req_reg.value);
        end
    end

    // Update cells on the update step
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            entry_reg  <= entry_next;
            status_reg <= status_next;
        end
    end

    // Hold fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (cmd.update)
        begin
            fill_reg <= fill_next;
        end
    end

    // Register the match vector on the match step
    always_ff @(posedge clk)
    begin
        if (cmd.match)
        begin
            match_reg <= match_next;
        end
    end

    // Present the result
    assign rsp.found  = |match_reg;
    assign rsp.count  = 5'(fill_reg);
    assign rsp.status = status_reg;

`ifndef SYNTHESIS
    // Fill level never exceeds the depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(fill_reg) <= CMP_W'(DEPTH))
        else $error("fill level beyond depth");

    // A rejected push leaves the stack full and reports it
    a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && req_reg.op == csd_pkg::OP_PUSH && CMP_W'(fill_reg) == CMP_W'(DEPTH)
        |=> fill_reg == $past(fill_reg) && status_reg == csd_pkg::ST_FULL)
        else $error("push on full changed the stack");

    // Fill level moves only on the update step
    a_fill_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.update |=> $stable(fill_reg))
        else $error("fill level changed outside update");
`endif

endmodule

[rtl/char_stack_with_delete_and_search.sv]
// Top level of the byte stack with push, pop, positional delete and search.
//
// Usage:
//   Drive req (op, value, position) and raise start. A request transfers at
//   the rising edge where start is high and busy is low; busy then stays high
//   until the result has been shown.
//   Each request gives one result on rsp (found, count, status), valid for
//   exactly one cycle while done is high. The receiver cannot stall: the
//   result transfers at the edge that ends that cycle.
//   Sequence: after the transfer edge the controller updates the cell
//   row, registers the per-cell match vector, then reports with done high.
//   A new request may transfer in the cycle after done; busy holds off any
//   new request while one is in progress.
//   found reflects the stack after the step; count is the fill level kept
//   to five bits.
//   Reset empties the stack (fill level zero); cell contents are not cleared
//   and are never seen before being written.
module char_stack_with_delete_and_search #(
    parameter int DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  csd_pkg::req_t  req,
    output logic           busy,
    output logic           done,
    output csd_pkg::rsp_t  rsp
);

    csd_pkg::cmd_t cmd;

    // Sequence each request
    csd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    // Hold cells, fill level and result
    csd_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

    // Mark the result cycle
    assign done = cmd.report;

endmodule

[tb/tb_char_stack_with_delete_and_search.sv]
// Self-checking testbench for the byte stack with push, pop, positional delete and search.
module tb_char_stack_with_delete_and_search;

    localparam int DEPTH = 16;
    localparam int RANDOM_ITEMS = 1340;
    localparam int QUIET_TAIL = 150;
    localparam int STALL_LIMIT = 500;
    localparam int DRAIN_CYCLES = 8;

    // Operation mix for one segment of random traffic
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    // One pending request with its lead-in gap and drain flag
    typedef struct {
        csd_pkg::req_t req;
        int unsigned   gap;
        bit            drain;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    csd_pkg::req_t req = '0;
    logic busy;
    logic done;
    csd_pkg::rsp_t rsp;

    pending_t      request_q[$];
    csd_pkg::rsp_t answer_q[$];
    int unsigned   mismatches = 0;

    // Predictor copy of the stack
    logic [7:0]  stack_image[DEPTH];
    int unsigned stack_level = 0;

    // Driver bookkeeping
    int unsigned gap_left = 0;
    bit          gap_armed = 1'b0;
    int unsigned in_flight = 0;
    pending_t    next_item;

    int unsigned stall_cycles = 0;

    char_stack_with_delete_and_search #(
        .DEPTH(DEPTH)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Apply one request to the predicted stack and form its answer
    task automatic stack_step(input csd_pkg::req_t r, output csd_pkg::rsp_t answer);
        int unsigned slot;
        logic [1:0]  st;
        bit          hit;
        st = csd_pkg::ST_OK;
        case (r.op)
            csd_pkg::OP_PUSH:
            begin
                if (stack_level >= DEPTH)
                    st = csd_pkg::ST_FULL;
                else
                begin
                    stack_image[stack_level] = r.value;
                    stack_level++;
                end
            end
            csd_pkg::OP_POP:
            begin
                if (stack_level == 0)
                    st = csd_pkg::ST_POP_EMPTY;
                else
                    stack_level--;
            end
            csd_pkg::OP_DELETE:
            begin
                if (r.position == 0 || r.position > stack_level)
                    st = csd_pkg::ST_BEYOND;
                else
                begin
                    // close up the entries above the removed one
                    slot = stack_level - r.position;
                    for (int i = slot; i + 1 < stack_level; i++)
                        stack_image[i] = stack_image[i + 1];
                    stack_level--;
                end
            end
            default:
            begin
            end
        endcase
        // presence is checked after the step for every operation
        hit = 1'b0;
        for (int i = 0; i < stack_level; i++)
            if (stack_image[i] == r.value)
                hit = 1'b1;
        answer.found = hit;
        answer.count = 5'(stack_level);
        answer.status = st;
    endtask

    task automatic add_request(input logic [1:0] op, input logic [7:0] value,
                               input logic [4:0] position, input int unsigned gap,
                               input bit drain);
        pending_t p;
        p.req.op = op;
        p.req.value = value;
        p.req.position = position;
        p.gap = gap;
        p.drain = drain;
        request_q.push_back(p);
    endtask

    function automatic logic [1:0] pick_op(input mix_t mix);
        int unsigned roll;
        int unsigned w_push;
        int unsigned w_pop;
        int unsigned w_del;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                w_push = 65;
                w_pop = 5;
                w_del = 10;
            end
            MIX_DRAIN:
            begin
                w_push = 15;
                w_pop = 35;
                w_del = 30;
            end
            default:
            begin
                w_push = 30;
                w_pop = 20;
                w_del = 25;
            end
        endcase
        if (roll < w_push)
            return csd_pkg::OP_PUSH;
        if (roll < w_push + w_pop)
            return csd_pkg::OP_POP;
        if (roll < w_push + w_pop + w_del)
            return csd_pkg::OP_DELETE;
        return csd_pkg::OP_SEARCH;
    endfunction

    // Drive requests from the pending queue, holding each until it transfers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
            gap_left = 0;
            gap_armed = 1'b0;
            in_flight = 0;
        end
        else
        begin
            if (start && !busy)
                in_flight++;
            if (done)
                in_flight--;
            if (start && busy)
            begin
                // hold the offered request
            end
            else if (request_q.size() == 0)
                start <= 1'b0;
            else
            begin
                if (!gap_armed)
                begin
                    gap_left = request_q[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (request_q[0].drain && in_flight != 0)
                    start <= 1'b0;
                else
                begin
                    next_item = request_q.pop_front();
                    req <= next_item.req;
                    start <= 1'b1;
                    gap_armed = 1'b0;
                end
            end
        end
    end

    // Check each result, then predict any request that transfers
    always @(posedge clk)
    begin
        csd_pkg::rsp_t want;
        csd_pkg::rsp_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got = rsp;
                if (answer_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (got.found !== want.found)
                    begin
                        mismatches++;
                        $display("%0t: found mismatch, expected %0d, actual %0d",
                                 $time, want.found, got.found);
                    end
                    if (got.count !== want.count)
                    begin
                        mismatches++;
                        $display("%0t: count mismatch, expected %0d, actual %0d",
                                 $time, want.count, got.count);
                    end
                    if (got.status !== want.status)
                    begin
                        mismatches++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
            if (start && !busy)
            begin
                stack_step(req, want);
                answer_q.push_back(want);
            end
        end
    end

    // End the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        mix_t        mix;
        logic [7:0]  value;
        logic [4:0]  position;
        int unsigned gap;
        int unsigned roll;

        // Directed: extreme bytes, hit and miss, delete at bottom, top and beyond
        add_request(csd_pkg::OP_PUSH,   8'h00, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_PUSH,   8'hFF, 5'd16, 0, 1'b0);
        add_request(csd_pkg::OP_SEARCH, 8'hFF, 5'd31, 0, 1'b0);
        add_request(csd_pkg::OP_SEARCH, 8'h00, 5'd0,  0, 1'b0);
        add_request(csd_pkg::OP_SEARCH, 8'h5A, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_PUSH,   8'hA5, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_DELETE, 8'h00, 5'd3,  0, 1'b0);
        add_request(csd_pkg::OP_SEARCH, 8'h00, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_DELETE, 8'hA5, 5'd0,  0, 1'b0);
        add_request(csd_pkg::OP_DELETE, 8'hA5, 5'd31, 0, 1'b0);
        add_request(csd_pkg::OP_DELETE, 8'hA5, 5'd3,  0, 1'b0);
        add_request(csd_pkg::OP_DELETE, 8'hFF, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_POP,    8'hFF, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_POP,    8'hFF, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_DELETE, 8'h00, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_SEARCH, 8'h00, 5'd1,  0, 1'b0);
        add_request(csd_pkg::OP_PUSH,   8'h7F, 5'd2,  3, 1'b0);
        add_request(csd_pkg::OP_PUSH,   8'h80, 5'd2,  0, 1'b0);
        add_request(csd_pkg::OP_DELETE, 8'h80, 5'd2,  0, 1'b0);
        add_request(csd_pkg::OP_SEARCH, 8'h80, 5'd2,  0, 1'b1);

        // Random: each segment picks filling, draining or an even mix at random
        mix = MIX_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
            begin
                roll = $urandom_range(0, 2);
                mix = (roll == 0) ? MIX_FILL : (roll == 1) ? MIX_DRAIN : MIX_EVEN;
            end
            // favor a small pool of bytes so searches hit
            if ($urandom_range(0, 1) == 0)
                value = 8'($urandom_range(0, 7));
            else
                value = 8'($urandom_range(0, 255));
            roll = $urandom_range(0, 99);
            if (roll < 70)
                position = 5'($urandom_range(1, 16));
            else if (roll < 85)
                position = 5'($urandom_range(1, 4));
            else
                position = 5'($urandom_range(0, 31));
            gap = 0;
            if (n < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 5) == 0)
                gap = $urandom_range(1, 19);
            add_request(pick_op(mix), value, position, gap, n % 300 == 150);
        end

        // Hold reset, then release it at a rising edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for the queue to empty and every answer to arrive
        do
            @(negedge clk);
        while (request_q.size() != 0 || start || answer_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && answer_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[char_stack_with_delete_and_search.f]
rtl/csd_pkg.sv
rtl/csd_ctrl.sv
rtl/csd_dp.sv
rtl/char_stack_with_delete_and_search.sv
tb/tb_char_stack_with_delete_and_search.sv
